// File: hdl/mssbm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-signature byte matcher package
// Field widths, item mode codes and the control bundle shared by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mssbm_pkg;

	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int POS_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 7;
	localparam int START_W  = 14;

	localparam logic [MODE_W-1:0] MODE_WRITE_BYTE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET_LENGTH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCAN_BYTE  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NEW_FILE   = 2'd3;

	// Control that every cell of the chain sees in the same cycle.
	typedef struct packed {
		logic              step;     // advance the partial-match bits by one byte
		logic              clear;    // drop all partial matches
		logic [BYTE_W-1:0] data;     // byte being scanned or written
		logic [SLOT_W-1:0] wr_slot;  // slot addressed by a signature byte write
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/mssbm_if.sv
// ----------------------------------------------------------------------------
// Multi-signature byte matcher channels
// Valid/ready channels for input items and for match results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mssbm_item_if;
	logic                           valid;
	logic                           ready;
	logic [mssbm_pkg::MODE_W-1:0]   mode;
	logic [mssbm_pkg::SLOT_W-1:0]   slot;
	logic [mssbm_pkg::POS_W-1:0]    position;
	logic [mssbm_pkg::BYTE_W-1:0]   byte_value;
	logic [mssbm_pkg::LEN_W-1:0]    sig_length;

	modport source (output valid, mode, slot, position, byte_value, sig_length,
		input ready);
	modport sink (input valid, mode, slot, position, byte_value, sig_length,
		output ready);
endinterface

interface mssbm_result_if;
	logic                           valid;
	logic                           ready;
	logic [mssbm_pkg::START_W-1:0]  match_start;
	logic [mssbm_pkg::SLOT_W-1:0]   match_slot;
	logic [mssbm_pkg::LEN_W-1:0]    match_length;
	logic                           last;

	modport source (output valid, match_start, match_slot, match_length, last,
		input ready);
	modport sink (input valid, match_start, match_slot, match_length, last,
		output ready);
endinterface

`default_nettype wire

// File: hdl/mssbm_cell.sv
// ----------------------------------------------------------------------------
// Multi-signature byte matcher cell
// Holds one byte position of every signature and the partial-match bit of
// every slot at that position; passes the bits on to the next position.
// ----------------------------------------------------------------------------
`default_nettype none

module mssbm_cell #(
	parameter int SLOTS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire mssbm_pkg::cell_ctl_t ctl,
	input  wire                      wr_en,
	input  wire  [SLOTS-1:0]         d_in,
	output logic [SLOTS-1:0]         d_out
);

	logic [mssbm_pkg::BYTE_W-1:0] sig_q [SLOTS];
	logic [SLOTS-1:0]             eq;

	always_ff @(posedge clk) begin
		for (int s = 0; s < SLOTS; s++) begin
			if (wr_en && int'(ctl.wr_slot) == s) begin
				sig_q[s] <= ctl.data;
			end
		end
	end

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			eq[s] = (sig_q[s] == ctl.data);
		end
	end

	// A bit is set when the signature prefix ending here equals the latest bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (ctl.clear) begin
			d_out <= '0;
		end else if (ctl.step) begin
			d_out <= d_in & eq;
		end
	end

endmodule

`default_nettype wire

// File: hdl/multi_signature_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// Multi-signature byte matcher
// Finds every occurrence of up to SLOTS byte signatures in a scanned file.
// ----------------------------------------------------------------------------
// Each signature position is a cell holding that byte of every slot and one
// partial-match bit per slot, so all signatures are checked in parallel as a
// file byte is scanned. A scanned byte passes through ST_EVAL and then, if it
// completes any matches, ST_EMIT, where the result register emits one match
// per cycle while results.ready allows; no new item is accepted until the
// block is back in ST_RUN. The first scanned byte after one or more signature
// byte writes (unless a new file starts first) is held off while the block
// notices the stale chain and replays the window through the chain in ST_REPLAY
// to rebuild the partial matches against the new signature contents.
`default_nettype none

module multi_signature_byte_matcher_core #(
	parameter int SLOTS          = 16,
	parameter int MAX_SIG_LEN    = 64,
	parameter int MAX_FILE_BYTES = 16384
) (
	input  wire              clk,
	input  wire              arst_n,
	mssbm_item_if.sink       items,
	mssbm_result_if.source   results
);

	localparam int CNT_W = $clog2(MAX_FILE_BYTES + 1);
	localparam int REP_W = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
	localparam int N_W   = $clog2(MAX_SIG_LEN + 1);

	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_REPLAY = 2'd1;
	localparam logic [1:0] ST_EVAL   = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]                       state_q;
	logic                             dirty_q;
	logic [CNT_W-1:0]                 seen_q;
	logic [REP_W-1:0]                 rep_q;
	logic [mssbm_pkg::LEN_W-1:0]      len_q [SLOTS];
	logic [mssbm_pkg::BYTE_W-1:0]     win_q [MAX_SIG_LEN];
	logic [SLOTS-1:0]                 hits_q;

	logic                             out_valid_q;
	logic [mssbm_pkg::START_W-1:0]    start_q;
	logic [mssbm_pkg::SLOT_W-1:0]     oslot_q;
	logic [mssbm_pkg::LEN_W-1:0]      olen_q;
	logic                             last_q;

	logic [SLOTS-1:0]                 d_w [MAX_SIG_LEN+1];
	logic [MAX_SIG_LEN-1:0]           wr_sel;
	mssbm_pkg::cell_ctl_t             ctl;

	logic                             acc;
	logic                             scan_go;
	logic                             rep_valid;
	logic [N_W-1:0]                   held;
	logic [SLOTS-1:0]                 hits_now;
	logic [SLOTS-1:0]                 hits_rest;
	logic [mssbm_pkg::SLOT_W-1:0]     pick;
	logic                             load_out;

	assign items.ready = (state_q == ST_RUN) &&
		!(dirty_q && items.mode == mssbm_pkg::MODE_SCAN_BYTE);
	assign acc = items.valid && items.ready;
	assign scan_go = acc && items.mode == mssbm_pkg::MODE_SCAN_BYTE &&
		int'(seen_q) < MAX_FILE_BYTES;

	assign held = (int'(seen_q) >= MAX_SIG_LEN) ? N_W'(MAX_SIG_LEN) : N_W'(seen_q);
	// Only the last held bytes of the window belong to the current file.
	assign rep_valid = (int'(rep_q) + int'(held)) >= MAX_SIG_LEN;

	always_comb begin
		ctl.wr_slot = items.slot;
		if (state_q == ST_REPLAY) begin
			ctl.step  = 1'b1;
			ctl.clear = !rep_valid;
			ctl.data  = win_q[MAX_SIG_LEN-1];
		end else begin
			ctl.step  = scan_go;
			ctl.clear = acc && items.mode == mssbm_pkg::MODE_NEW_FILE;
			ctl.data  = items.byte_value;
		end
	end

	assign d_w[0] = '1;

	genvar gj;
	generate
		for (gj = 0; gj < MAX_SIG_LEN; gj++) begin : g_cell
			if (gj < (1 << mssbm_pkg::POS_W)) begin : g_wr
				assign wr_sel[gj] = acc && items.mode == mssbm_pkg::MODE_WRITE_BYTE &&
					items.position == mssbm_pkg::POS_W'(gj) && int'(items.slot) < SLOTS;
			end else begin : g_nowr
				assign wr_sel[gj] = 1'b0;
			end
			mssbm_cell #(.SLOTS(SLOTS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.wr_en  (wr_sel[gj]),
				.d_in   (d_w[gj]),
				.d_out  (d_w[gj+1])
			);
		end
	endgenerate

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			hits_now[s] = 1'b0;
			for (int j = 0; j < MAX_SIG_LEN; j++) begin
				hits_now[s] = hits_now[s] | (d_w[j+1][s] && int'(len_q[s]) == j + 1);
			end
		end
	end

	always_comb begin
		pick = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (hits_q[s]) begin
				pick = mssbm_pkg::SLOT_W'(s);
			end
		end
		hits_rest = hits_q;
		for (int s = 0; s < SLOTS; s++) begin
			if (int'(pick) == s) begin
				hits_rest[s] = 1'b0;
			end
		end
	end

	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || results.ready);

	always_ff @(posedge clk) begin
		if (state_q == ST_REPLAY) begin
			win_q[0] <= win_q[MAX_SIG_LEN-1];
			for (int i = 1; i < MAX_SIG_LEN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end else if (scan_go) begin
			win_q[0] <= items.byte_value;
			for (int i = 1; i < MAX_SIG_LEN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
		if (load_out) begin
			start_q <= mssbm_pkg::START_W'(seen_q - CNT_W'(len_q[pick]));
			oslot_q <= pick;
			olen_q  <= len_q[pick];
			last_q  <= (hits_rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			dirty_q     <= 1'b0;
			seen_q      <= '0;
			rep_q       <= '0;
			hits_q      <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				len_q[s] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (items.valid && !items.ready && state_q == ST_RUN) begin
						state_q <= ST_REPLAY;
						rep_q   <= '0;
					end
					if (acc) begin
						unique case (items.mode)
							mssbm_pkg::MODE_WRITE_BYTE: begin
								dirty_q <= 1'b1;
							end
							mssbm_pkg::MODE_SET_LENGTH: begin
								for (int s = 0; s < SLOTS; s++) begin
									if (int'(items.slot) == s) begin
										len_q[s] <= (int'(items.sig_length) > MAX_SIG_LEN) ?
											mssbm_pkg::LEN_W'(MAX_SIG_LEN) : items.sig_length;
									end
								end
							end
							mssbm_pkg::MODE_SCAN_BYTE: begin
								if (scan_go) begin
									seen_q  <= seen_q + CNT_W'(1);
									state_q <= ST_EVAL;
								end
							end
							mssbm_pkg::MODE_NEW_FILE: begin
								seen_q  <= '0;
								dirty_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_REPLAY: begin
					rep_q <= rep_q + REP_W'(1);
					if (int'(rep_q) == MAX_SIG_LEN - 1) begin
						dirty_q <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_EVAL: begin
					hits_q  <= hits_now;
					state_q <= (hits_now == '0) ? ST_RUN : ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						hits_q <= hits_rest;
						if (hits_rest == '0) begin
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.match_start  = start_q;
	assign results.match_slot   = oslot_q;
	assign results.match_length = olen_q;
	assign results.last         = last_q;

endmodule

`default_nettype wire

// File: test/multi_signature_byte_matcher_core_tb.sv
// ----------------------------------------------------------------------------
// Multi-signature byte matcher testbench
// Loads signature tables, scans files through the block with random gaps and
// stalls on both channels, and checks every match against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_signature_byte_matcher_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int SIG_LEN = 64;
	localparam int FILE_MAX = 16384;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [mssbm_pkg::START_W-1:0] start;
		logic [mssbm_pkg::SLOT_W-1:0]  slot;
		logic [mssbm_pkg::LEN_W-1:0]   length;
		logic                          last;
	} match_t;

	// Predicts matches from the accepted transactions and holds them in order.
	class match_scoreboard;
		logic [mssbm_pkg::BYTE_W-1:0] sig_bytes [SLOTS][SIG_LEN];
		int                           sig_len [SLOTS];
		logic [mssbm_pkg::BYTE_W-1:0] window [SIG_LEN];
		int                           seen;
		match_t                       pending [$];
		int                           errors;

		function void clear_state();
			foreach (sig_bytes[s, p]) sig_bytes[s][p] = '0;
			foreach (sig_len[s]) sig_len[s] = 0;
			foreach (window[i]) window[i] = '0;
			seen = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void note_item(logic [mssbm_pkg::MODE_W-1:0] mode,
			logic [mssbm_pkg::SLOT_W-1:0] slot, logic [mssbm_pkg::POS_W-1:0] pos,
			logic [mssbm_pkg::BYTE_W-1:0] data, logic [mssbm_pkg::LEN_W-1:0] len);
			int n;
			int first;
			bit hit;
			match_t m;
			case (mode)
				mssbm_pkg::MODE_WRITE_BYTE: sig_bytes[slot][pos] = data;
				mssbm_pkg::MODE_SET_LENGTH: sig_len[slot] = (len > SIG_LEN) ? SIG_LEN : len;
				mssbm_pkg::MODE_NEW_FILE: begin
					foreach (window[i]) window[i] = '0;
					seen = 0;
				end
				default: begin
					if (seen < FILE_MAX) begin
						for (int i = SIG_LEN - 1; i > 0; i--) window[i] = window[i-1];
						window[0] = data;
						seen++;
						first = pending.size();
						for (int s = 0; s < SLOTS; s++) begin
							n = sig_len[s];
							if (n == 0 || n > seen) continue;
							hit = 1;
							for (int j = 0; j < n; j++)
								if (sig_bytes[s][j] != window[n-1-j]) hit = 0;
							if (hit) begin
								m.start = mssbm_pkg::START_W'(seen - n);
								m.slot = mssbm_pkg::SLOT_W'(s);
								m.length = mssbm_pkg::LEN_W'(n);
								m.last = 0;
								pending.push_back(m);
							end
						end
						if (pending.size() > first) pending[pending.size()-1].last = 1;
					end
				end
			endcase
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_match(match_t got);
			match_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected match %p", got));
				return;
			end
			want = pending.pop_front();
			if (got.start !== want.start)
				report($sformatf("start %0d, expected %0d", got.start, want.start));
			if (got.slot !== want.slot)
				report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
			if (got.length !== want.length)
				report($sformatf("length %0d, expected %0d", got.length, want.length));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b", got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	mssbm_item_if items ();
	mssbm_result_if results ();

	multi_signature_byte_matcher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items.sink),
		.results(results.source)
	);

	match_scoreboard board;
	bit written [SLOTS][SIG_LEN];
	int idle_cycles;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Valid stays up after a transaction until the next falling edge, where the
	// next item replaces it or a gap begins.
	task automatic send_item(logic [mssbm_pkg::MODE_W-1:0] mode, int slot, int pos,
		int data, int len);
		int gap;
		logic [mssbm_pkg::SLOT_W-1:0] slot_v;
		logic [mssbm_pkg::POS_W-1:0]  pos_v;
		logic [mssbm_pkg::BYTE_W-1:0] data_v;
		logic [mssbm_pkg::LEN_W-1:0]  len_v;
		gap = gap_length();
		slot_v = mssbm_pkg::SLOT_W'(slot);
		pos_v = mssbm_pkg::POS_W'(pos);
		data_v = mssbm_pkg::BYTE_W'(data);
		len_v = mssbm_pkg::LEN_W'(len);
		@(negedge clk);
		if (gap != 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items.valid <= 1'b1;
		items.mode <= mode;
		items.slot <= slot_v;
		items.position <= pos_v;
		items.byte_value <= data_v;
		items.sig_length <= len_v;
		do @(posedge clk); while (!items.ready);
		board.note_item(mode, slot_v, pos_v, data_v, len_v);
		if (mode == mssbm_pkg::MODE_WRITE_BYTE) written[slot_v][pos_v] = 1;
	endtask

	// A length is only set where every covered position has been written.
	task automatic load_signature(int slot, int len, logic [mssbm_pkg::BYTE_W-1:0] sig []);
		for (int p = 0; p < len; p++)
			send_item(mssbm_pkg::MODE_WRITE_BYTE, slot, p, int'(sig[p]), 0);
		send_item(mssbm_pkg::MODE_SET_LENGTH, slot, 0, $urandom, len);
	endtask

	task automatic scan(int data);
		send_item(mssbm_pkg::MODE_SCAN_BYTE, $urandom, $urandom, data, $urandom);
	endtask

	// Highest length whose positions have all been written.
	function automatic int written_span(int slot);
		int n;
		n = 0;
		while (n < SIG_LEN && written[slot][n]) n++;
		return n;
	endfunction

	logic [mssbm_pkg::BYTE_W-1:0] alphabet [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

	function automatic int rand_byte();
		return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
			: int'(alphabet[$urandom_range(0, 3)]);
	endfunction

	// Result side: random stalls, check at the rising edge.
	initial begin
		int stall;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = gap_length();
			results.ready <= (stall == 0) ? 1'b1 : 1'b0;
			if (stall != 0) begin
				repeat (stall - 1) @(negedge clk);
				@(negedge clk);
				results.ready <= 1'b1;
			end
			do @(posedge clk); while (!results.valid);
			board.check_match('{results.match_start, results.match_slot,
				results.match_length, results.last});
		end
	end

	// Watchdog on cycles without any transaction.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((items.valid && items.ready) || (results.valid && results.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired");
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [mssbm_pkg::BYTE_W-1:0] sig [];
		int len;
		int slot;
		int k;
		int span;
		board = new();
		board.clear_state();
		foreach (written[s, p]) written[s][p] = 0;
		arst_n = 1'b0;
		items.valid = 1'b0;
		items.mode = mssbm_pkg::MODE_WRITE_BYTE;
		items.slot = '0;
		items.position = '0;
		items.byte_value = '0;
		items.sig_length = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a one-byte and a two-byte signature that complete on the
		// same byte, then a full-length signature set through an oversized
		// length, and an emptied slot.
		sig = new[SIG_LEN];
		foreach (sig[i]) sig[i] = 8'hFF;
		load_signature(0, 1, sig);
		load_signature(15, 2, sig);
		scan(0);
		scan(255);
		scan(255);
		for (int p = 2; p < SIG_LEN; p++)
			send_item(mssbm_pkg::MODE_WRITE_BYTE, 15, p, 255, 0);
		send_item(mssbm_pkg::MODE_SET_LENGTH, 15, 0, 0, 127);
		send_item(mssbm_pkg::MODE_SET_LENGTH, 0, 0, 0, 0);
		scan(255);
		send_item(mssbm_pkg::MODE_NEW_FILE, 0, 0, 0, 0);

		// Random phases: small alphabet so matches are frequent.
		for (int phase = 0; phase < 6; phase++) begin
			k = $urandom_range(1, 3);
			for (int i = 0; i < k; i++) begin
				slot = $urandom_range(0, SLOTS - 1);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, SIG_LEN)
					: $urandom_range(1, 4);
				sig = new[len];
				foreach (sig[j]) sig[j] = alphabet[$urandom_range(0, 3)];
				load_signature(slot, len, sig);
			end
			if ($urandom_range(0, 3) == 0) begin
				slot = $urandom_range(0, SLOTS - 1);
				span = written_span(slot);
				send_item(mssbm_pkg::MODE_SET_LENGTH, slot, $urandom, $urandom,
					$urandom_range(0, span));
			end
			if ($urandom_range(0, 2) == 0) send_item(mssbm_pkg::MODE_NEW_FILE, $urandom,
				$urandom, $urandom, $urandom);
			for (int i = 0; i < 30; i++) scan(rand_byte());
		end

		@(negedge clk);
		items.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
hdl/mssbm_pkg.sv
hdl/mssbm_if.sv
hdl/mssbm_cell.sv
hdl/multi_signature_byte_matcher_core.sv
test/multi_signature_byte_matcher_core_tb.sv
